// ===== hdl/uule_pkg.sv =====
// uule_pkg: shared types, constants and the character mapping of the line encoder
// no dependencies; imported by every module of the block

package uule_pkg;

    localparam int DEF_MAX_LINE_BYTES = 45;
    localparam int LINE_CAP           = 45;   // bytes per line, keeps a line within 64 chars
    localparam int CNT_W              = 6;    // byte count and line length width
    localparam int CFG_IDX_W          = 1;
    localparam int CFG_DATA_W         = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_AS_SPACE = 1'b1;

    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] BACKQUOTE    = 8'h60;
    localparam logic [7:0] SPACE_CHAR   = 8'h20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_RD,
        ST_CH,
        ST_NL,
        ST_ZLEN,
        ST_ZNL
    } t_state;

    typedef struct packed {
        logic             idle;
        logic [CNT_W-1:0] count;
    } t_ctrl_stat;

    // six-bit value to printable character
    function automatic logic [7:0] enc_char(input logic [5:0] v, input logic zsp);
        logic [7:0] c;
        if (v == 6'd0) begin
            c = zsp ? SPACE_CHAR : BACKQUOTE;
        end else begin
            c = {2'b00, v} + SPACE_CHAR;
        end
        return c;
    endfunction

endpackage

// ===== hdl/uule_line_mem.sv =====
// uule_line_mem: line buffer, one write port and one registered read port
// depends on uule_pkg

module uule_line_mem
    import uule_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_LINE_BYTES
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [7:0]               o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/uule_ctrl.sv =====
// uule_ctrl: byte collection and line sequencer, reads the buffer back in groups of three
// depends on uule_pkg; drives uule_line_mem

module uule_ctrl
    import uule_pkg::*;
#(
    parameter int MAX_LINE_BYTES = DEF_MAX_LINE_BYTES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [7:0]                        i_byte,
    input  logic                              i_eos,
    output t_ctrl_stat                        o_status,
    input  logic [CNT_W-1:0]                  i_line_bytes,
    input  logic                              i_zero_as_space,
    output logic                              o_mem_we,
    output logic [$clog2(MAX_LINE_BYTES)-1:0] o_mem_waddr,
    output logic [7:0]                        o_mem_wdata,
    output logic                              o_mem_re,
    output logic [$clog2(MAX_LINE_BYTES)-1:0] o_mem_raddr,
    input  logic [7:0]                        i_mem_rdata,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [7:0]                        o_out_char,
    output logic                              o_out_last
);

    localparam int AW  = $clog2(MAX_LINE_BYTES);
    localparam int CAP = (MAX_LINE_BYTES < LINE_CAP) ? MAX_LINE_BYTES : LINE_CAP;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_len, n_len;
    logic             r_last, n_last;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic [1:0]       r_sub, n_sub;
    logic [23:0]      r_grp, n_grp;
    logic             r_pend, n_pend;
    logic             r_pend_zero, n_pend_zero;

    logic             accept;
    logic             room;
    logic [CNT_W-1:0] eff;
    logic [CNT_W-1:0] count_inc;
    logic [5:0]       sextet;
    logic             in_line;

    // effective line length: zero means one, capped at the smaller of the buffer size and LINE_CAP
    always_comb begin
        if (i_line_bytes == '0) begin
            eff = CNT_W'(1);
        end else if (i_line_bytes > CNT_W'(CAP)) begin
            eff = CNT_W'(CAP);
        end else begin
            eff = i_line_bytes;
        end
    end

    assign accept    = i_valid && (r_state == ST_IDLE);
    assign room      = r_count < CNT_W'(MAX_LINE_BYTES);
    assign count_inc = room ? r_count + CNT_W'(1) : r_count;
    assign in_line   = r_ptr < r_len;

    assign o_mem_we    = accept && room;
    assign o_mem_waddr = r_count[AW-1:0];
    assign o_mem_wdata = i_byte;
    assign o_mem_raddr = r_ptr[AW-1:0];

    assign o_status.idle  = (r_state == ST_IDLE);
    assign o_status.count = r_count;

    always_comb begin
        case (r_sub)
            2'd0:    sextet = r_grp[23:18];
            2'd1:    sextet = r_grp[17:12];
            2'd2:    sextet = r_grp[11:6];
            2'd3:    sextet = r_grp[5:0];
            default: sextet = r_grp[5:0];
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_len       = r_len;
        n_last      = r_last;
        n_ptr       = r_ptr;
        n_sub       = r_sub;
        n_grp       = r_grp;
        n_pend      = 1'b0;
        n_pend_zero = r_pend_zero;
        o_mem_re    = 1'b0;
        o_out_valid = 1'b0;
        o_out_char  = NEWLINE_CHAR;
        o_out_last  = 1'b0;

        // read data lands in the cycle after its request
        if (r_pend) begin
            n_grp = {r_grp[15:0], (r_pend_zero ? 8'h00 : i_mem_rdata)};
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_len = count_inc;
                    if (count_inc >= eff || i_eos) begin
                        n_count = '0;
                        n_last  = i_eos;
                        n_state = ST_LEN;
                    end else begin
                        n_count = count_inc;
                    end
                end
            end
            ST_LEN: begin
                o_out_valid = 1'b1;
                o_out_char  = enc_char(r_len, i_zero_as_space);
                if (i_out_ready) begin
                    n_ptr   = '0;
                    n_sub   = '0;
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                // bytes past the end of the line pad as zero
                o_mem_re    = in_line;
                n_pend      = 1'b1;
                n_pend_zero = !in_line;
                n_ptr       = r_ptr + CNT_W'(1);
                n_sub       = r_sub + 2'd1;
                if (r_sub == 2'd2) begin
                    n_sub   = '0;
                    n_state = ST_CH;
                end
            end
            ST_CH: begin
                o_out_valid = !r_pend;
                o_out_char  = enc_char(sextet, i_zero_as_space);
                if (!r_pend && i_out_ready) begin
                    n_sub = r_sub + 2'd1;
                    if (r_sub == 2'd3) begin
                        n_sub   = '0;
                        n_state = in_line ? ST_RD : ST_NL;
                    end
                end
            end
            ST_NL: begin
                o_out_valid = 1'b1;
                o_out_last  = !r_last;
                if (i_out_ready) begin
                    n_state = r_last ? ST_ZLEN : ST_IDLE;
                end
            end
            ST_ZLEN: begin
                o_out_valid = 1'b1;
                o_out_char  = enc_char(6'd0, i_zero_as_space);
                if (i_out_ready) begin
                    n_state = ST_ZNL;
                end
            end
            ST_ZNL: begin
                o_out_valid = 1'b1;
                o_out_last  = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len       <= n_len;
        r_last      <= n_last;
        r_ptr       <= n_ptr;
        r_sub       <= n_sub;
        r_grp       <= n_grp;
        r_pend_zero <= n_pend_zero;
    end

endmodule

// ===== hdl/uuencode_line_encoder.sv =====
// uuencode_line_encoder: top level, configuration registers and output register
// depends on uule_pkg, uule_ctrl and uule_line_mem

// Raw bytes stream in one per item and collect in a line buffer memory. When the
// line is full (line_bytes, 1..45, zero taken as one) or a byte arrives with tlast
// set, the block sends one text line, one character per item: a length character,
// four characters for each group of three bytes (big-endian, short group padded
// with zeros) and a newline; after the final line of a stream a zero-length line
// follows. Output tlast marks the last character caused by one input item. A byte
// that completes no line leaves the block idle and ready for the next byte. To
// send a line, each group is read back from the buffer over its single read port
// one byte at a time through its registered read, then its four characters leave
// at one per cycle while the output register is not held by back-pressure; input
// is held off meanwhile. Configuration must be written only while the block is
// idle; the block itself does not enforce this.

module uuencode_line_encoder
    import uule_pkg::*;
#(
    parameter int MAX_LINE_BYTES = DEF_MAX_LINE_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input bytes
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [7:0] data_byte
    input  logic                  i_s_axis_tlast,   // end_of_stream
    // encoded characters
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [7:0]            o_m_axis_tdata,   // [7:0] out_char
    output logic                  o_m_axis_tlast,   // run_last
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW  = $clog2(MAX_LINE_BYTES);
    localparam int CAP = (MAX_LINE_BYTES < LINE_CAP) ? MAX_LINE_BYTES : LINE_CAP;

    // configuration registers
    logic [CNT_W-1:0] r_line_bytes;
    logic             r_zero_as_space;

    // output register between the sequencer and the stream
    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_last;

    t_ctrl_stat       ctrl_stat;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [7:0]       mem_rdata;
    logic             seq_valid;
    logic             seq_ready;
    logic [7:0]       seq_char;
    logic             seq_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bytes    <= CNT_W'(LINE_CAP);
            r_zero_as_space <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LINE_BYTES:    r_line_bytes    <= i_cfg_data[CNT_W-1:0];
                CFG_ZERO_AS_SPACE: r_zero_as_space <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // the sequencer may load a new character whenever the register drains
    assign seq_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_ready) begin
            r_out_valid <= seq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_ready && seq_valid) begin
            r_out_char <= seq_char;
            r_out_last <= seq_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_char;
    assign o_m_axis_tlast  = r_out_last;
    assign o_s_axis_tready = ctrl_stat.idle;

    uule_ctrl #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_axis_tvalid),
        .i_byte          (i_s_axis_tdata),
        .i_eos           (i_s_axis_tlast),
        .o_status        (ctrl_stat),
        .i_line_bytes    (r_line_bytes),
        .i_zero_as_space (r_zero_as_space),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_mem_re        (mem_re),
        .o_mem_raddr     (mem_raddr),
        .i_mem_rdata     (mem_rdata),
        .o_out_valid     (seq_valid),
        .i_out_ready     (seq_ready),
        .o_out_char      (seq_char),
        .o_out_last      (seq_last)
    );

    uule_line_mem #(
        .DEPTH (MAX_LINE_BYTES)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

`ifndef ASSERT_OFF
    // every run of characters closes with a newline
    a_last_is_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (o_m_axis_tdata == NEWLINE_CHAR))
        else $error("run closed by a character other than newline");

    // a waiting character that does not close its run means a line is still in progress
    a_busy_mid_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |-> !o_s_axis_tready)
        else $error("input taken while a line is still being sent");

    // between lines the buffer never holds a full line
    a_count_below_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_stat.idle |-> (ctrl_stat.count < CNT_W'(CAP)))
        else $error("byte count reached the line capacity while idle");
`endif

endmodule

// ===== tb/sv/uule_char_checker.sv =====
`timescale 1ns / 100ps
// uule_char_checker: watches the byte, character and register channels of the line encoder,
// predicts every encoded character and compares each one as it leaves the block
// depends on uule_pkg

module uule_char_checker
    import uule_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [7:0]            i_s_tdata,
    input  logic                  i_s_tlast,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [7:0]            i_m_tdata,
    input  logic                  i_m_tlast,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_run_done,
    output int                    o_pending,
    output int                    o_fail_cnt
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    t_text_char       due_chars[$];
    logic [7:0]       line_mem[LINE_CAP];
    int               held = 0;
    logic [CNT_W-1:0] line_len;
    logic             zero_sp;
    int               fails = 0;
    bit               tail_checked = 0;

    // six-bit group value to its printable character
    function automatic logic [7:0] printable(input logic [5:0] v, input logic zsp);
        if (v == 6'd0) begin
            return zsp ? SPACE_CHAR : BACKQUOTE;
        end
        return {2'b00, v} + 8'd32;
    endfunction

    // add one raw byte to the line and queue the text it completes, if any
    task automatic encode_byte(input logic [7:0] b, input logic eos);
        int         eff;
        int         i;
        logic [23:0] grp;
        logic [7:0] line_txt[$];
        t_text_char c;
        eff = line_len;
        if (eff == 0) eff = 1;
        if (eff > LINE_CAP) eff = LINE_CAP;
        if (held < LINE_CAP) begin
            line_mem[held] = b;
            held++;
        end
        if (held >= eff || eos) begin
            line_txt.push_back(printable(held[5:0], zero_sp));
            for (i = 0; i < held; i += 3) begin
                grp = {line_mem[i],
                       (i + 1 < held) ? line_mem[i + 1] : 8'h00,
                       (i + 2 < held) ? line_mem[i + 2] : 8'h00};
                line_txt.push_back(printable(grp[23:18], zero_sp));
                line_txt.push_back(printable(grp[17:12], zero_sp));
                line_txt.push_back(printable(grp[11:6], zero_sp));
                line_txt.push_back(printable(grp[5:0], zero_sp));
            end
            line_txt.push_back(NEWLINE_CHAR);
            held = 0;
            if (eos) begin
                // empty closing line
                line_txt.push_back(printable(6'd0, zero_sp));
                line_txt.push_back(NEWLINE_CHAR);
            end
            foreach (line_txt[k]) begin
                c.ch   = line_txt[k];
                c.last = (k == line_txt.size() - 1);
                due_chars.push_back(c);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_text_char c;
        if (!i_rst_n) begin
            held     = 0;
            line_len = DEF_MAX_LINE_BYTES[CNT_W-1:0];
            zero_sp  = 1'b0;
            due_chars.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LINE_BYTES:    line_len = i_cfg_data[CNT_W-1:0];
                    CFG_ZERO_AS_SPACE: zero_sp = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                encode_byte(i_s_tdata, i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (due_chars.size() == 0) begin
                    $error("out_char: nothing expected, actual %h", i_m_tdata);
                    fails++;
                end else begin
                    c = due_chars.pop_front();
                    if (i_m_tdata !== c.ch) begin
                        $error("out_char: expected %h, actual %h", c.ch, i_m_tdata);
                        fails++;
                    end
                    if (i_m_tlast !== c.last) begin
                        $error("run_last: expected %b, actual %b", c.last, i_m_tlast);
                        fails++;
                    end
                end
            end
            if (i_run_done && !tail_checked) begin
                tail_checked = 1;
                if (due_chars.size() != 0) begin
                    $error("out_char: %0d characters never arrived", due_chars.size());
                    fails++;
                end
            end
        end
        o_pending  <= due_chars.size();
        o_fail_cnt <= fails;
    end

endmodule

// ===== tb/sv/uuencode_line_encoder_tb.sv =====
`timescale 1ns / 100ps
// uuencode_line_encoder_tb: stimulus and verdict for the uuencode line encoder
// depends on uule_pkg, uuencode_line_encoder and uule_char_checker

module uuencode_line_encoder_tb;
    import uule_pkg::*;

    // slowest legal item: a full line of up to 64 characters, each held back by
    // receiver stalls, plus the block's own work and a sender gap; this limit
    // leaves a wide margin over the whole run
    localparam int CYCLE_LIMIT = 800000;
    // a byte that completes no line may still be in flight when nothing is due
    localparam int IDLE_GAP    = 4;
    localparam int TAIL_WAIT   = 20;
    localparam int PHASE_BYTES = 18;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } t_raw_byte;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [7:0]            s_tdata = 8'h00;
    logic                  s_tlast = 1'b0;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_LINE_BYTES;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  run_done = 1'b0;
    bit                    idle_on = 1'b1;
    int                    stall_left = 0;

    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [7:0]            o_m_axis_tdata;
    logic                  o_m_axis_tlast;
    logic                  o_cfg_ready;
    int                    pending;
    int                    fail_cnt;

    t_raw_byte             byte_q[$];

    uuencode_line_encoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // prediction and comparison live in the checker; it reports what is still
    // due and how many failures it has seen
    uule_char_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (o_s_axis_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .i_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (o_m_axis_tdata),
        .i_m_tlast   (o_m_axis_tlast),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_run_done  (run_done),
        .o_pending   (pending),
        .o_fail_cnt  (fail_cnt)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // receiver back-pressure: random stall bursts while idling is on
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog
    initial begin : watchdog
        int cyc;
        cyc = 0;
        while (cyc < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void add_byte(input logic [7:0] b, input logic eos);
        t_raw_byte it;
        it.data = b;
        it.eos  = eos;
        byte_q.push_back(it);
    endfunction

    // send everything queued; valid stays up between items unless a gap is drawn
    task automatic drive_bytes();
        t_raw_byte it;
        while (byte_q.size() > 0) begin
            it = byte_q.pop_front();
            if (idle_on && $urandom_range(0, 4) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= it.data;
            s_tlast  <= it.eos;
            @(posedge i_clk);
            while (!o_s_axis_tready) @(posedge i_clk);
        end
        s_tvalid <= 1'b0;
    endtask

    // pending is registered, so wait for the next edge before trusting a zero
    task automatic wait_idle();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (IDLE_GAP) @(posedge i_clk);
    endtask

    // write line length and zero mapping back to back once the block is quiet
    task automatic set_format(input int lb, input bit zsp);
        wait_idle();
        for (int r = 0; r < 2; r++) begin
            cfg_valid <= 1'b1;
            if (r == 0) begin
                cfg_index <= CFG_LINE_BYTES;
                cfg_data  <= lb[CFG_DATA_W-1:0];
            end else begin
                cfg_index <= CFG_ZERO_AS_SPACE;
                cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, zsp};
            end
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int  lb;
        int  sent;
        int  len;
        bit  closes;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset format: zeros as backquote, full groups of zeros and ones, then
        // a one-byte short group padded with zeros on the final line
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h80, 1'b1);
        drive_bytes();

        // three-byte lines, zero as space: one full line, then a one-byte final line
        set_format(3, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(8'h02, 1'b0);
        add_byte(8'h7F, 1'b1);
        // stream end landing exactly on a full line
        add_byte(8'hC3, 1'b0);
        add_byte(8'h3C, 1'b0);
        add_byte(8'h5A, 1'b1);
        drive_bytes();

        // line length zero behaves as one byte per line
        set_format(0, 1'b0);
        add_byte(8'hAA, 1'b0);
        add_byte(8'h55, 1'b1);
        drive_bytes();

        // oversize length saturates; five bytes give no line yet
        set_format(63, 1'b0);
        repeat (5) add_byte(8'($urandom_range(0, 255)), 1'b0);
        drive_bytes();
        // length lowered below what is held: next byte flushes all six
        set_format(4, 1'b0);
        add_byte(8'h96, 1'b0);
        // a lone final byte
        add_byte(8'hE7, 1'b1);
        drive_bytes();

        set_format(1, 1'b1);
        add_byte(8'h00, 1'b1);
        drive_bytes();

        // random streams under a spread of formats; last phase runs with no idling
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: lb = 45;
                1: lb = 1;
                2: lb = 63;
                3: lb = 0;
                default: lb = $urandom_range(2, 44);
            endcase
            if (ph == 5) idle_on <= 1'b0;
            set_format(lb, 1'($urandom_range(0, 1)));
            sent = 0;
            while (sent < PHASE_BYTES) begin
                // mostly short streams, now and then one spanning full lines
                len    = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
                // some streams stop without an end marker and leave a partial line
                closes = ($urandom_range(0, 6) != 0);
                for (int k = 0; k < len; k++) begin
                    add_byte(8'($urandom_range(0, 255)), closes && (k == len - 1));
                end
                sent += len;
            end
            drive_bytes();
        end

        // drain, then allow for any trailing activity before the verdict
        wait_idle();
        repeat (TAIL_WAIT) @(posedge i_clk);
        run_done <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
